@@ design/slau_pkg.sv @@
package slau_pkg;

	// number format
	localparam int WORD_BITS  = 32;
	localparam int FRAC_BITS  = 24;
	localparam int INT_BITS   = WORD_BITS - FRAC_BITS;
	localparam int SUM_BITS   = WORD_BITS + 4;
	localparam int GAMMA_BITS = 26;
	localparam int AXIS_BITS  = 2;
	localparam int CFG_INDEX_BITS = 1;
	// latency of the divider, the square root and the matching context line
	localparam int LAT = WORD_BITS + 2;

	typedef logic signed [WORD_BITS-1:0]   word_t;
	typedef logic        [WORD_BITS-1:0]   uword_t;
	typedef logic        [2*WORD_BITS-1:0] dword_t;
	typedef logic signed [2*WORD_BITS-1:0] prod_t;
	typedef logic signed [SUM_BITS-1:0]    sum_t;

	localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam word_t FONE = word_t'({1'b1, {FRAC_BITS{1'b0}}});
	localparam logic [GAMMA_BITS-1:0] GAMMA_RESET = GAMMA_BITS'(23488102);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_FACE_AXIS   = 1'b0,
		REG_GAMMA_RATIO = 1'b1
	} cfg_reg_t;

	typedef enum logic [AXIS_BITS-1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	// sign and special-case flags that ride along the divider stages
	typedef struct packed {
		logic neg;
		logic dz;
		logic ovf;
		logic a_pos;
		logic a_neg;
	} div_flags_t;

	// per-item context carried down the whole pipeline
	typedef struct packed {
		logic             valid;
		logic             err;
		axis_t            ax;
		word_t            rl;
		word_t            rr;
		word_t [2:0]      ml;
		word_t [2:0]      mr;
		word_t            el;
		word_t            er;
		word_t            pl;
		word_t            pr;
		word_t            dp;
		word_t            vl;
		word_t            vr;
		word_t            ch;
		word_t            vn;
		word_t            g;
		word_t            md;
	} ctx_t;

	// clamp a widened sum back to the word range
	function automatic word_t sat_sum(input sum_t x);
		if (x > sum_t'(WMAX)) return WMAX;
		if (x < sum_t'(WMIN)) return WMIN;
		return x[WORD_BITS-1:0];
	endfunction

	// scale a full product back to the word, truncating toward zero
	function automatic word_t fmul_fin(input prod_t p);
		prod_t adj;
		prod_t sh;
		adj = p[2*WORD_BITS-1] ? p + prod_t'({FRAC_BITS{1'b1}}) : p;
		sh  = adj >>> FRAC_BITS;
		if (sh > prod_t'(WMAX)) return WMAX;
		if (sh < prod_t'(WMIN)) return WMIN;
		return sh[WORD_BITS-1:0];
	endfunction

	function automatic word_t abs_sat(input word_t x);
		if (x == WMIN) return WMAX;
		return x[WORD_BITS-1] ? -x : x;
	endfunction

	function automatic prod_t smul(input word_t a, input word_t b);
		return prod_t'(a) * prod_t'(b);
	endfunction

endpackage

@@ design/slau_face_if.sv @@
interface slau_face_if import slau_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t left_density;
	word_t left_mom_x;
	word_t left_mom_y;
	word_t left_mom_z;
	word_t left_energy;
	word_t left_pressure;
	word_t right_density;
	word_t right_mom_x;
	word_t right_mom_y;
	word_t right_mom_z;
	word_t right_energy;
	word_t right_pressure;

	modport source (output valid, output left_density, output left_mom_x, output left_mom_y,
		output left_mom_z, output left_energy, output left_pressure, output right_density,
		output right_mom_x, output right_mom_y, output right_mom_z, output right_energy,
		output right_pressure, input ready);
	modport sink (input valid, input left_density, input left_mom_x, input left_mom_y,
		input left_mom_z, input left_energy, input left_pressure, input right_density,
		input right_mom_x, input right_mom_y, input right_mom_z, input right_energy,
		input right_pressure, output ready);
endinterface

@@ design/slau_flux_if.sv @@
interface slau_flux_if import slau_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t mass_flux;
	word_t mom_x_flux;
	word_t mom_y_flux;
	word_t mom_z_flux;
	word_t energy_flux;
	logic  state_error;

	modport source (output valid, output mass_flux, output mom_x_flux, output mom_y_flux,
		output mom_z_flux, output energy_flux, output state_error, input ready);
	modport sink (input valid, input mass_flux, input mom_x_flux, input mom_y_flux,
		input mom_z_flux, input energy_flux, input state_error, output ready);
endinterface

@@ design/slau_div.sv @@
module slau_div import slau_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  word_t num,
	input  word_t den,
	output word_t quot
);

	uword_t     rem_s [WORD_BITS+1];
	uword_t     lo_s  [WORD_BITS+1];
	uword_t     quo_s [WORD_BITS+1];
	uword_t     dvs_s [WORD_BITS+1];
	div_flags_t flg_s [WORD_BITS+1];
	word_t      quot_q;

	uword_t     mag_a;
	uword_t     mag_b;
	div_flags_t flg_n;

	// magnitudes and the overflow test for num * 2^frac / den
	always_comb begin
		mag_a       = num[WORD_BITS-1] ? uword_t'(-num) : uword_t'(num);
		mag_b       = den[WORD_BITS-1] ? uword_t'(-den) : uword_t'(den);
		flg_n.neg   = num[WORD_BITS-1] ^ den[WORD_BITS-1];
		flg_n.dz    = (den == '0);
		flg_n.ovf   = ({{INT_BITS{1'b0}}, mag_a} >= {mag_b, {INT_BITS{1'b0}}});
		flg_n.a_pos = !num[WORD_BITS-1] && (num != '0);
		flg_n.a_neg = num[WORD_BITS-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= uword_t'(mag_a >> INT_BITS);
			lo_s[0]  <= mag_a << FRAC_BITS;
			quo_s[0] <= '0;
			dvs_s[0] <= mag_b;
			flg_s[0] <= flg_n;
		end
	end

	// one quotient bit per stage, restoring
	for (genvar k = 1; k <= WORD_BITS; k++) begin : g_step
		logic [WORD_BITS:0] r_in;
		logic [WORD_BITS:0] r_sub;
		logic               ge;
		assign r_in  = {rem_s[k-1], lo_s[k-1][WORD_BITS-1]};
		assign ge    = (r_in >= {1'b0, dvs_s[k-1]});
		assign r_sub = r_in - {1'b0, dvs_s[k-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? r_sub[WORD_BITS-1:0] : r_in[WORD_BITS-1:0];
				lo_s[k]  <= lo_s[k-1] << 1;
				quo_s[k] <= {quo_s[k-1][WORD_BITS-2:0], ge};
				dvs_s[k] <= dvs_s[k-1];
				flg_s[k] <= flg_s[k-1];
			end
		end
	end

	// sign, saturation and the zero divisor
	always_ff @(posedge clk) begin
		if (en) begin
			if (flg_s[WORD_BITS].dz) begin
				quot_q <= flg_s[WORD_BITS].a_pos ? WMAX :
					(flg_s[WORD_BITS].a_neg ? WMIN : '0);
			end else if (flg_s[WORD_BITS].ovf) begin
				quot_q <= flg_s[WORD_BITS].neg ? WMIN : WMAX;
			end else if (flg_s[WORD_BITS].neg) begin
				quot_q <= (quo_s[WORD_BITS] > uword_t'(WMIN)) ? WMIN :
					word_t'(-quo_s[WORD_BITS]);
			end else begin
				quot_q <= quo_s[WORD_BITS][WORD_BITS-1] ? WMAX : word_t'(quo_s[WORD_BITS]);
			end
		end
	end

	assign quot = quot_q;

endmodule

@@ design/slau_sqrt.sv @@
module slau_sqrt import slau_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  word_t arg,
	output word_t root
);

	localparam int RW = WORD_BITS + 4;

	logic [RW-1:0] rem_s  [WORD_BITS+1];
	dword_t        rad_s  [WORD_BITS+1];
	uword_t        res_s  [WORD_BITS+1];
	logic          zero_s [WORD_BITS+1];
	word_t         root_q;

	// radicand is arg * 2^frac; non-positive arguments give zero
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			rad_s[0]  <= dword_t'(uword_t'(arg)) << FRAC_BITS;
			res_s[0]  <= '0;
			zero_s[0] <= arg[WORD_BITS-1] || (arg == '0);
		end
	end

	// one root bit per stage
	for (genvar k = 1; k <= WORD_BITS; k++) begin : g_step
		logic [RW-1:0] r_in;
		logic [RW-1:0] trial;
		logic          ge;
		assign r_in  = {rem_s[k-1][RW-3:0], rad_s[k-1][2*WORD_BITS-1 -: 2]};
		assign trial = {2'b00, res_s[k-1], 2'b01};
		assign ge    = (r_in >= trial);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? r_in - trial : r_in;
				rad_s[k]  <= rad_s[k-1] << 2;
				res_s[k]  <= {res_s[k-1][WORD_BITS-2:0], ge};
				zero_s[k] <= zero_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s[WORD_BITS]) root_q <= '0;
			else if (res_s[WORD_BITS][WORD_BITS-1]) root_q <= WMAX;
			else root_q <= word_t'(res_s[WORD_BITS]);
		end
	end

	assign root = root_q;

endmodule

@@ design/slau_delay.sv @@
module slau_delay import slau_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  ctx_t din,
	output ctx_t dout
);

	ctx_t           pipe_s [LAT];
	logic [LAT-1:0] vld_s;

	// valid bits of the context line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], din.valid};
		end
	end

	// context payload, matched to the arithmetic unit latency
	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s[0] <= din;
			for (int i = 1; i < LAT; i++) pipe_s[i] <= pipe_s[i-1];
		end
	end

	always_comb begin
		dout       = pipe_s[LAT-1];
		dout.valid = vld_s[LAT-1];
	end

endmodule

@@ design/slau_interface_flux_unit.sv @@
// SLAU upwind flux unit for one cell face per item, all values signed Q8.24 and saturated.
// A face item is taken in every cycle the pipeline advances; its flux item leaves after five
// passes through 34-stage pipelined dividers and square roots (input stage, one quotient or
// root bit per stage, output stage) plus the multiply stages between them. The whole pipeline
// moves as one and halts only while a finished flux item waits at the output. A non-positive
// density or pressure gives state_error with all fluxes zero. The user must write face_axis
// and gamma_ratio via the wr_* port while no item is in flight; the block does not enforce it.
module slau_interface_flux_unit import slau_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [CFG_INDEX_BITS-1:0] wr_index,
	input  logic [GAMMA_BITS-1:0]     wr_data,
	slau_face_if.sink                 face,
	slau_flux_if.source               flux
);

	logic [AXIS_BITS-1:0]  face_axis_q;
	logic [GAMMA_BITS-1:0] gamma_q;

	logic adv;
	axis_t ax_n;
	word_t gam;

	ctx_t ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5, ctx_s6, ctx_s7, ctx_s8;
	ctx_t ctx_s9, ctx_s10, ctx_s11, ctx_s12, ctx_s13, ctx_s14, ctx_s15;
	ctx_t ctx_dly_a, ctx_dly_b, ctx_dly_c, ctx_dly_d, ctx_dly_e;
	ctx_t ctx_n1, ctx_n3, ctx_n6, ctx_n9, ctx_n13;

	prod_t gpl_p_s1, gpr_p_s1;
	word_t gpl_s2, gpr_s2;
	word_t ul [3];
	word_t ur [3];
	word_t tl, tr;
	prod_t sq_p_s3 [6];
	prod_t nl_p_s3, nr_p_s3;
	word_t tl_s3, tr_s3;
	word_t sq_s4 [6];
	word_t nl_s4, nr_s4, tl_s4, tr_s4;
	word_t vv_arg_s5, vn_num_s5, vn_den_s5, tl_s5, tr_s5;
	word_t cl, cr, vv, vn;
	word_t cl_s6, cr_s6, vv_s6;
	word_t mc, an, bn;
	word_t omc_s7, an_s7, bn_s7;
	prod_t chi_p_s8, g_p_s8;
	word_t chi_s9;
	word_t qd;
	prod_t p1_s10, p2_s10, p3_s10, p4_s10;
	word_t vnp_s11, vnn_s11, qdp_s11;
	prod_t ml_p_s12, mr_p_s12;
	word_t qdp_s12;
	word_t rs;
	word_t kq;
	prod_t km_p_s14 [3];
	prod_t ke_p_s14, kp_p_s14;
	word_t ps_s14;
	word_t res_s15 [5];
	logic  flux_valid_q;
	word_t flux_res_q [5];
	logic  flux_err_q;

	word_t vl_a, vr_a;
	sum_t  sq_sum;
	word_t md_full;
	sum_t  md_half;
	word_t md_n;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_axis_q <= AXIS_X;
			gamma_q     <= GAMMA_RESET;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_FACE_AXIS:   face_axis_q <= wr_data[AXIS_BITS-1:0];
				REG_GAMMA_RATIO: gamma_q     <= wr_data;
			endcase
		end
	end

	// whole pipeline advances unless a flux item is held at the output
	assign adv        = !flux_valid_q || flux.ready;
	assign face.ready = adv;

	// axis code three folds onto z
	always_comb begin
		case (face_axis_q)
			AXIS_X:  ax_n = AXIS_X;
			AXIS_Y:  ax_n = AXIS_Y;
			default: ax_n = AXIS_Z;
		endcase
	end

	assign gam = word_t'(gamma_q);

	// s1: capture the face, state check, pressure difference, gamma products
	always_comb begin
		ctx_n1       = '0;
		ctx_n1.valid = face.valid;
		ctx_n1.err   = (face.left_density <= 0) || (face.right_density <= 0) ||
			(face.left_pressure <= 0) || (face.right_pressure <= 0);
		ctx_n1.ax    = ax_n;
		ctx_n1.rl    = face.left_density;
		ctx_n1.rr    = face.right_density;
		ctx_n1.ml    = {face.left_mom_z, face.left_mom_y, face.left_mom_x};
		ctx_n1.mr    = {face.right_mom_z, face.right_mom_y, face.right_mom_x};
		ctx_n1.el    = face.left_energy;
		ctx_n1.er    = face.right_energy;
		ctx_n1.pl    = face.left_pressure;
		ctx_n1.pr    = face.right_pressure;
		ctx_n1.dp    = sat_sum(sum_t'(face.left_pressure) - sum_t'(face.right_pressure));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctx_s1.valid <= 1'b0;
		else if (adv) ctx_s1 <= ctx_n1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gpl_p_s1 <= smul(gam, face.left_pressure);
			gpr_p_s1 <= smul(gam, face.right_pressure);
		end
	end

	// s2: scale gamma products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctx_s2.valid <= 1'b0;
		else if (adv) ctx_s2 <= ctx_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gpl_s2 <= fmul_fin(gpl_p_s1);
			gpr_s2 <= fmul_fin(gpr_p_s1);
		end
	end

	// velocities and gamma * p / rho
	for (genvar i = 0; i < 3; i++) begin : g_vel
		slau_div u_div_ul (.clk(clk), .en(adv), .num(ctx_s2.ml[i]), .den(ctx_s2.rl), .quot(ul[i]));
		slau_div u_div_ur (.clk(clk), .en(adv), .num(ctx_s2.mr[i]), .den(ctx_s2.rr), .quot(ur[i]));
	end
	slau_div u_div_tl (.clk(clk), .en(adv), .num(gpl_s2), .den(ctx_s2.rl), .quot(tl));
	slau_div u_div_tr (.clk(clk), .en(adv), .num(gpr_s2), .den(ctx_s2.rr), .quot(tr));
	slau_delay u_dly_a (.clk(clk), .arst_n(arst_n), .en(adv), .din(ctx_s2), .dout(ctx_dly_a));

	assign vl_a = ul[ctx_dly_a.ax];
	assign vr_a = ur[ctx_dly_a.ax];

	// s3: squared velocities and density-weighted normal speeds
	always_comb begin
		ctx_n3    = ctx_dly_a;
		ctx_n3.vl = vl_a;
		ctx_n3.vr = vr_a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctx_s3.valid <= 1'b0;
		else if (adv) ctx_s3 <= ctx_n3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sq_p_s3[i]     <= smul(ul[i], ul[i]);
				sq_p_s3[i + 3] <= smul(ur[i], ur[i]);
			end
			nl_p_s3 <= smul(ctx_dly_a.rl, abs_sat(vl_a));
			nr_p_s3 <= smul(ctx_dly_a.rr, abs_sat(vr_a));
			tl_s3   <= tl;
			tr_s3   <= tr;
		end
	end

	// s4: scale products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctx_s4.valid <= 1'b0;
		else if (adv) ctx_s4 <= ctx_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 6; i++) sq_s4[i] <= fmul_fin(sq_p_s3[i]);
			nl_s4 <= fmul_fin(nl_p_s3);
			nr_s4 <= fmul_fin(nr_p_s3);
			tl_s4 <= tl_s3;
			tr_s4 <= tr_s3;
		end
	end

	// s5: sums for the mean speed and the averaged normal speed
	always_comb begin
		sq_sum = '0;
		for (int i = 0; i < 6; i++) sq_sum = sq_sum + sum_t'(sq_s4[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctx_s5.valid <= 1'b0;
		else if (adv) ctx_s5 <= ctx_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vv_arg_s5 <= sat_sum(sq_sum >>> 1);
			vn_num_s5 <= sat_sum(sum_t'(nl_s4) + sum_t'(nr_s4));
			vn_den_s5 <= sat_sum(sum_t'(ctx_s4.rl) + sum_t'(ctx_s4.rr));
			tl_s5     <= tl_s4;
			tr_s5     <= tr_s4;
		end
	end

	// sound speeds, mean speed, averaged normal speed
	slau_sqrt u_sqrt_cl (.clk(clk), .en(adv), .arg(tl_s5), .root(cl));
	slau_sqrt u_sqrt_cr (.clk(clk), .en(adv), .arg(tr_s5), .root(cr));
	slau_sqrt u_sqrt_vv (.clk(clk), .en(adv), .arg(vv_arg_s5), .root(vv));
	slau_div u_div_vn (.clk(clk), .en(adv), .num(vn_num_s5), .den(vn_den_s5), .quot(vn));
	slau_delay u_dly_b (.clk(clk), .arst_n(arst_n), .en(adv), .din(ctx_s5), .dout(ctx_dly_b));

	// s6: mean sound speed
	always_comb begin
		ctx_n6    = ctx_dly_b;
		ctx_n6.vn = vn;
		ctx_n6.ch = sat_sum((sum_t'(cl) + sum_t'(cr)) >>> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctx_s6.valid <= 1'b0;
		else if (adv) ctx_s6 <= ctx_n6;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cl_s6 <= cl;
			cr_s6 <= cr;
			vv_s6 <= vv;
		end
	end

	// mach number and the one-sided normal mach numbers
	slau_div u_div_mc (.clk(clk), .en(adv), .num(vv_s6), .den(ctx_s6.ch), .quot(mc));
	slau_div u_div_an (.clk(clk), .en(adv), .num(ctx_s6.vl), .den(cl_s6), .quot(an));
	slau_div u_div_bn (.clk(clk), .en(adv), .num(ctx_s6.vr), .den(cr_s6), .quot(bn));
	slau_delay u_dly_c (.clk(clk), .arst_n(arst_n), .en(adv), .din(ctx_s6), .dout(ctx_dly_c));

	// s7: clamps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctx_s7.valid <= 1'b0;
		else if (adv) ctx_s7 <= ctx_dly_c;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			omc_s7 <= sat_sum(sum_t'(FONE) - sum_t'((mc > FONE) ? FONE : mc));
			an_s7  <= (an > 0) ? '0 : ((an < -FONE) ? -FONE : an);
			bn_s7  <= (bn < 0) ? '0 : ((bn > FONE) ? FONE : bn);
		end
	end

	// s8: chi and g products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctx_s8.valid <= 1'b0;
		else if (adv) ctx_s8 <= ctx_s7;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			chi_p_s8 <= smul(omc_s7, omc_s7);
			g_p_s8   <= smul(an_s7, bn_s7);
		end
	end

	// s9: chi and blending weight g
	always_comb begin
		ctx_n9   = ctx_s8;
		ctx_n9.g = sat_sum(-sum_t'(fmul_fin(g_p_s8)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctx_s9.valid <= 1'b0;
		else if (adv) ctx_s9 <= ctx_n9;
	end

	always_ff @(posedge clk) begin
		if (adv) chi_s9 <= fmul_fin(chi_p_s8);
	end

	// chi over mean sound speed
	slau_div u_div_qd (.clk(clk), .en(adv), .num(chi_s9), .den(ctx_s9.ch), .quot(qd));
	slau_delay u_dly_d (.clk(clk), .arst_n(arst_n), .en(adv), .din(ctx_s9), .dout(ctx_dly_d));

	// s10: blended normal speed and pressure term products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctx_s10.valid <= 1'b0;
		else if (adv) ctx_s10 <= ctx_dly_d;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s10 <= smul(sat_sum(sum_t'(FONE) - sum_t'(ctx_dly_d.g)), ctx_dly_d.vn);
			p2_s10 <= smul(ctx_dly_d.g, abs_sat(ctx_dly_d.vl));
			p3_s10 <= smul(ctx_dly_d.g, abs_sat(ctx_dly_d.vr));
			p4_s10 <= smul(qd, ctx_dly_d.dp);
		end
	end

	// s11: positive and negative blended speeds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctx_s11.valid <= 1'b0;
		else if (adv) ctx_s11 <= ctx_s10;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vnp_s11 <= sat_sum(sum_t'(fmul_fin(p1_s10)) + sum_t'(fmul_fin(p2_s10)));
			vnn_s11 <= sat_sum(sum_t'(fmul_fin(p1_s10)) + sum_t'(fmul_fin(p3_s10)));
			qdp_s11 <= fmul_fin(p4_s10);
		end
	end

	// s12: mass flux partial products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctx_s12.valid <= 1'b0;
		else if (adv) ctx_s12 <= ctx_s11;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ml_p_s12 <= smul(ctx_s11.rl, sat_sum(sum_t'(ctx_s11.vl) + sum_t'(vnp_s11)));
			mr_p_s12 <= smul(ctx_s11.rr, sat_sum(sum_t'(ctx_s11.vr) - sum_t'(vnn_s11)));
			qdp_s12  <= qdp_s11;
		end
	end

	// s13: mass flux, halved toward zero
	always_comb begin
		md_full = sat_sum(sum_t'(fmul_fin(ml_p_s12)) + sum_t'(fmul_fin(mr_p_s12)) -
			sum_t'(qdp_s12));
		md_half = (sum_t'(md_full) + sum_t'(md_full[WORD_BITS-1])) >>> 1;
		md_n    = md_half[WORD_BITS-1:0];
		ctx_n13    = ctx_s12;
		ctx_n13.md = md_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctx_s13.valid <= 1'b0;
		else if (adv) ctx_s13 <= ctx_n13;
	end

	// mass flux over upwind density
	assign rs = ctx_s13.md[WORD_BITS-1] ? ctx_s13.rr : ctx_s13.rl;
	slau_div u_div_k (.clk(clk), .en(adv), .num(ctx_s13.md), .den(rs), .quot(kq));
	slau_delay u_dly_e (.clk(clk), .arst_n(arst_n), .en(adv), .din(ctx_s13), .dout(ctx_dly_e));

	// s14: upwind products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctx_s14.valid <= 1'b0;
		else if (adv) ctx_s14 <= ctx_dly_e;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				km_p_s14[i] <= smul(kq, ctx_dly_e.md[WORD_BITS-1] ? ctx_dly_e.mr[i] :
					ctx_dly_e.ml[i]);
			end
			ke_p_s14 <= smul(kq, ctx_dly_e.md[WORD_BITS-1] ? ctx_dly_e.er : ctx_dly_e.el);
			kp_p_s14 <= smul(kq, ctx_dly_e.md[WORD_BITS-1] ? ctx_dly_e.pr : ctx_dly_e.pl);
			ps_s14   <= ctx_dly_e.md[WORD_BITS-1] ? ctx_dly_e.pr : ctx_dly_e.pl;
		end
	end

	// s15: fluxes with pressure terms, zeroed on a bad state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctx_s15.valid <= 1'b0;
		else if (adv) ctx_s15 <= ctx_s14;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (ctx_s14.err) begin
				for (int i = 0; i < 5; i++) res_s15[i] <= '0;
			end else begin
				res_s15[0] <= ctx_s14.md;
				for (int i = 0; i < 3; i++) begin
					if (ctx_s14.ax == axis_t'(i)) begin
						res_s15[i + 1] <= sat_sum(sum_t'(fmul_fin(km_p_s14[i])) + sum_t'(ps_s14));
					end else begin
						res_s15[i + 1] <= fmul_fin(km_p_s14[i]);
					end
				end
				res_s15[4] <= sat_sum(sum_t'(fmul_fin(ke_p_s14)) + sum_t'(fmul_fin(kp_p_s14)));
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) flux_valid_q <= 1'b0;
		else if (adv) flux_valid_q <= ctx_s15.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flux_res_q <= res_s15;
			flux_err_q <= ctx_s15.err;
		end
	end

	assign flux.valid       = flux_valid_q;
	assign flux.mass_flux   = flux_res_q[0];
	assign flux.mom_x_flux  = flux_res_q[1];
	assign flux.mom_y_flux  = flux_res_q[2];
	assign flux.mom_z_flux  = flux_res_q[3];
	assign flux.energy_flux = flux_res_q[4];
	assign flux.state_error = flux_err_q;

	// a bad state gives zero mass, x-momentum and energy fluxes
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		flux.valid && flux.state_error |->
			flux.mass_flux == '0 && flux.mom_x_flux == '0 && flux.energy_flux == '0)
		else $error("flux item with state error carries non-zero flux");

	// a held output freezes the last stage
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(ctx_s15) && $stable(flux_valid_q))
		else $error("pipeline moved during a stall");

	// non-positive density is flagged on entry
	a_err_entry: assert property (@(posedge clk) disable iff (!arst_n)
		face.valid && face.ready && (face.left_density <= 0 || face.right_density <= 0) |=>
			ctx_s1.valid && ctx_s1.err)
		else $error("bad density not flagged");

endmodule
